@@ hw/rtl/stream_close_handshake_fsm_assert.svh @@
// assertion macros for the stream close handshake controller
`ifndef STREAM_CLOSE_HANDSHAKE_FSM_ASSERT_SVH
`define STREAM_CLOSE_HANDSHAKE_FSM_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define SCH_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SCH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCH_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define SCH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

@@ hw/rtl/sch_pkg.sv @@
// types, codes and reset values shared by the close handshake controller
package sch_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DRAIN_TIMEOUT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CTRL_TIMEOUT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_RETRIES   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INITIATOR     = 8'd3;

    localparam logic [31:0] RST_DRAIN_TIMEOUT = 32'd30000;
    localparam logic [31:0] RST_CTRL_TIMEOUT  = 32'd1000;
    localparam logic [7:0]  RST_MAX_RETRIES   = 8'd3;
    localparam logic        RST_INITIATOR     = 1'b1;

    localparam logic [7:0] RSN_NORMAL  = 8'd0;
    localparam logic [7:0] RSN_TIMEOUT = 8'd1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CLOSED = 2'd1;
    localparam logic [1:0] ST_STATE  = 2'd2;

    typedef enum logic [1:0] {
        EV_TICK         = 2'd0,
        EV_LOCAL_CLOSE  = 2'd1,
        EV_PEER_CLOSE   = 2'd2,
        EV_READ_DRAINED = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        LIFE_OPEN    = 2'd0,
        LIFE_CLOSING = 2'd1,
        LIFE_CLOSED  = 2'd2
    } life_t;

    typedef enum logic [1:0] {
        PH_LOCAL_DRAIN  = 2'd0,
        PH_WAIT_ACK     = 2'd1,
        PH_REMOTE_DRAIN = 2'd2,
        PH_FINALIZE     = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic [7:0]  peer_reason;
        logic        send_queue_empty;
        logic        recv_queue_empty;
        logic        link_up;
        logic        payload_sent;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic       send_close;
        logic       send_ack;
        logic [7:0] ctrl_reason;
        logic       closed_now;
        logic [7:0] notify_reason;
        logic [1:0] life_state;
        logic [1:0] close_phase_out;
    } out_word_t;

    typedef struct packed {
        logic [31:0] drain_timeout;
        logic [31:0] ctrl_timeout;
        logic [7:0]  max_close_retries;
        logic        initiator;
    } cfg_t;

    typedef struct packed {
        life_t       life;
        phase_t      phase;
        logic [7:0]  reason_kept;
        logic [7:0]  retries_done;
        logic [31:0] drain_start;
        logic [31:0] last_ctrl_time;
    } state_t;

endpackage

@@ hw/rtl/sch_cfg_regs.sv @@
// configuration register file of the close handshake controller
module sch_cfg_regs
    import sch_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drain_timeout     <= RST_DRAIN_TIMEOUT;
            cfg_reg.ctrl_timeout      <= RST_CTRL_TIMEOUT;
            cfg_reg.max_close_retries <= RST_MAX_RETRIES;
            cfg_reg.initiator         <= RST_INITIATOR;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_DRAIN_TIMEOUT: begin
                    cfg_reg.drain_timeout <= cfg_data[31:0];
                end
                CFG_IDX_CTRL_TIMEOUT: begin
                    cfg_reg.ctrl_timeout <= cfg_data[31:0];
                end
                CFG_IDX_MAX_RETRIES: begin
                    cfg_reg.max_close_retries <= cfg_data[7:0];
                end
                CFG_IDX_INITIATOR: begin
                    cfg_reg.initiator <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/sch_engine.sv @@
// stream lifecycle state and the per-event close handshake logic
module sch_engine
    import sch_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_word_t  ev,
    input  cfg_t      cfg,
    output out_word_t result
);

    state_t      state_reg;
    state_t      state_next;
    out_word_t   res;

    logic [31:0] anchor;
    logic [31:0] tmo;
    logic [32:0] deadline;
    logic        expired;
    logic [7:0]  retries_inc;

    // one shared deadline compare, anchor picked by phase
    always_comb begin
        if (state_reg.phase == PH_WAIT_ACK) begin
            anchor = state_reg.last_ctrl_time;
            tmo    = cfg.ctrl_timeout;
        end else begin
            anchor = state_reg.drain_start;
            tmo    = cfg.drain_timeout;
        end
        deadline = {1'b0, anchor} + {1'b0, tmo};
        expired  = ({1'b0, ev.now_ms} >= deadline);
    end

    assign retries_inc = state_reg.retries_done + 8'd1;

    always_comb begin
        state_next = state_reg;
        res        = '0;
        res.status = ST_OK;

        case (func_t'(ev.func))
            EV_TICK: begin
                if (state_reg.life == LIFE_CLOSING && ev.link_up) begin
                    case (state_reg.phase)
                        PH_LOCAL_DRAIN: begin
                            if (ev.send_queue_empty) begin
                                state_next.phase          = PH_WAIT_ACK;
                                state_next.retries_done   = 8'd0;
                                state_next.last_ctrl_time = ev.now_ms;
                                res.send_close            = 1'b1;
                                res.ctrl_reason           = RSN_NORMAL;
                                if (cfg.max_close_retries == 8'd0) begin
                                    state_next.life   = LIFE_CLOSED;
                                    res.closed_now    = 1'b1;
                                    res.notify_reason = RSN_NORMAL;
                                end
                            end else if (expired) begin
                                state_next.reason_kept    = RSN_TIMEOUT;
                                state_next.last_ctrl_time = ev.now_ms;
                                res.send_close            = 1'b1;
                                res.ctrl_reason           = RSN_TIMEOUT;
                                state_next.life           = LIFE_CLOSED;
                                res.closed_now            = 1'b1;
                                res.notify_reason         = RSN_TIMEOUT;
                            end
                        end
                        PH_WAIT_ACK: begin
                            if (expired) begin
                                if (state_reg.retries_done < cfg.max_close_retries) begin
                                    // resend the close with the kept reason
                                    state_next.retries_done   = retries_inc;
                                    state_next.last_ctrl_time = ev.now_ms;
                                    res.send_close            = 1'b1;
                                    res.ctrl_reason           = state_reg.reason_kept;
                                    if (retries_inc == cfg.max_close_retries) begin
                                        state_next.life   = LIFE_CLOSED;
                                        res.closed_now    = 1'b1;
                                        res.notify_reason = state_reg.reason_kept;
                                    end
                                end else begin
                                    state_next.life   = LIFE_CLOSED;
                                    res.closed_now    = 1'b1;
                                    res.notify_reason = state_reg.reason_kept;
                                end
                            end
                        end
                        PH_REMOTE_DRAIN: begin
                            if (expired) begin
                                state_next.life   = LIFE_CLOSED;
                                res.closed_now    = 1'b1;
                                res.notify_reason = RSN_TIMEOUT;
                            end
                        end
                        default: begin
                            state_next.life   = LIFE_CLOSED;
                            res.closed_now    = 1'b1;
                            res.notify_reason = state_reg.reason_kept;
                        end
                    endcase
                end
            end
            EV_LOCAL_CLOSE: begin
                if (state_reg.life == LIFE_CLOSING) begin
                    if (state_reg.phase == PH_REMOTE_DRAIN) begin
                        state_next.reason_kept = RSN_NORMAL;
                        state_next.phase       = PH_FINALIZE;
                    end
                end else if (state_reg.life == LIFE_OPEN) begin
                    state_next.last_ctrl_time = ev.now_ms;
                    state_next.drain_start    = ev.now_ms;
                    state_next.reason_kept    = RSN_NORMAL;
                    state_next.retries_done   = 8'd0;
                    state_next.phase          = PH_LOCAL_DRAIN;
                    state_next.life           = LIFE_CLOSING;
                    if (cfg.initiator && !ev.payload_sent) begin
                        // nothing ever sent: close silently
                        state_next.life   = LIFE_CLOSED;
                        res.closed_now    = 1'b1;
                        res.notify_reason = RSN_NORMAL;
                    end else if (ev.send_queue_empty) begin
                        state_next.phase = PH_WAIT_ACK;
                        res.send_close   = 1'b1;
                        res.ctrl_reason  = RSN_NORMAL;
                        if (cfg.max_close_retries == 8'd0) begin
                            state_next.life   = LIFE_CLOSED;
                            res.closed_now    = 1'b1;
                            res.notify_reason = RSN_NORMAL;
                        end
                    end
                end
            end
            EV_PEER_CLOSE: begin
                if (state_reg.life == LIFE_CLOSED) begin
                    res.status = ST_CLOSED;
                end else if (ev.peer_reason != RSN_NORMAL) begin
                    res.send_ack      = 1'b1;
                    res.ctrl_reason   = ev.peer_reason;
                    state_next.life   = LIFE_CLOSED;
                    res.closed_now    = 1'b1;
                    res.notify_reason = ev.peer_reason;
                end else begin
                    res.send_ack    = 1'b1;
                    res.ctrl_reason = RSN_NORMAL;
                    if (state_reg.life == LIFE_CLOSING) begin
                        if (state_reg.phase == PH_LOCAL_DRAIN ||
                            state_reg.phase == PH_WAIT_ACK) begin
                            state_next.reason_kept = RSN_NORMAL;
                            state_next.phase       = PH_FINALIZE;
                        end
                    end else begin
                        state_next.reason_kept = RSN_NORMAL;
                        state_next.phase       = PH_REMOTE_DRAIN;
                        state_next.drain_start = ev.now_ms;
                        state_next.life        = LIFE_CLOSING;
                        if (ev.recv_queue_empty) begin
                            state_next.phase = PH_FINALIZE;
                        end
                    end
                end
            end
            default: begin
                if (state_reg.life == LIFE_CLOSED) begin
                    res.status = ST_CLOSED;
                end else if (state_reg.life == LIFE_CLOSING) begin
                    if (state_reg.phase != PH_REMOTE_DRAIN) begin
                        res.status = ST_STATE;
                    end else if (ev.recv_queue_empty) begin
                        state_next.phase = PH_FINALIZE;
                    end
                end
            end
        endcase

        res.life_state      = state_next.life;
        res.close_phase_out = state_next.phase;
    end

    assign result = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.life           <= LIFE_OPEN;
            state_reg.phase          <= PH_LOCAL_DRAIN;
            state_reg.reason_kept    <= 8'd0;
            state_reg.retries_done   <= 8'd0;
            state_reg.drain_start    <= 32'd0;
            state_reg.last_ctrl_time <= 32'd0;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/stream_close_handshake_fsm.sv @@
// top level of the per-stream close handshake controller
//
//  channel  | ports                              | moves
//  ---------+------------------------------------+------------------------------
//  event in | s_valid  s_ready  s_data           | one event word per handshake
//  result   | m_valid  m_ready  m_data           | one result word per event
//  config   | cfg_valid cfg_ready cfg_index/data | one register write
//
// an event word is taken into the input register, runs through the event
// logic and lands in the result register; one event per cycle is sustained
// while the result is not stalled, set by the single state update
// reset is synchronous and active low; it restores config defaults and an
// open stream in the local drain phase
// a stalled result holds the input register; s_ready then follows m_ready
`include "stream_close_handshake_fsm_assert.svh"

module stream_close_handshake_fsm
    import sch_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // event words in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    // result words out
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // input stage
    logic      in_valid_reg;
    in_word_t  in_data_reg;

    // result stage
    logic      m_valid_reg;
    out_word_t m_data_reg;

    cfg_t      cfg;
    out_word_t step_result;
    logic      advance;

    // the held event moves on when the result slot is free or being emptied
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    sch_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state only updates on the cycle the event reaches the result register
    sch_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .ev      (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload, no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= step_result;
        end
    end

    // a stalled result must hold the event stage full
    `SCH_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, m_valid_reg && !m_ready && in_valid_reg, !s_ready, "input taken while result stalled")
    // an event that leaves the input stage always shows up as a result
    `SCH_ASSERT_NEXT(a_advance_fills_result, aclk, aresetn, advance, m_valid_reg, "processed event lost")
    // a final close always leaves the stream closed
    `SCH_ASSERT_NOW(a_close_means_closed, aclk, aresetn, m_valid_reg && m_data_reg.closed_now, m_data_reg.life_state == LIFE_CLOSED, "closed_now without closed state")
    // an error status carries no requests
    `SCH_ASSERT_NOW(a_error_is_quiet, aclk, aresetn, m_valid_reg && m_data_reg.status != ST_OK, !m_data_reg.send_close && !m_data_reg.send_ack && !m_data_reg.closed_now, "error status with side effects")
    // close and ack never requested together
    `SCH_ASSERT_NOW(a_one_ctrl_msg, aclk, aresetn, m_valid_reg, !(m_data_reg.send_close && m_data_reg.send_ack), "close and ack in one word")
    // no control message means no control reason
    `SCH_ASSERT_NOW(a_reason_needs_msg, aclk, aresetn, m_valid_reg && !m_data_reg.send_close && !m_data_reg.send_ack, m_data_reg.ctrl_reason == RSN_NORMAL, "ctrl_reason without message")

endmodule
